// ===== rtl/core/tkl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkl_pkg: shared types and constants of the top-k lowest score table
// Table size, derived widths, operation codes and the sweep word that
// travels down the cell chain.
// ----------------------------------------------------------------------------
package tkl_pkg;

  localparam int TABLE_DEPTH = 64;

  localparam int KEY_W   = 64;
  localparam int SCORE_W = 32;
  localparam int OP_W    = 2;
  localparam int SLOT_W  = 6;
  localparam int LIMIT_W = 7;
  localparam int COUNT_W = 7;

  // Internal widths follow the table depth.
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_READ   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(64);

  // Word handed from one cell to the next during a sweep.
  typedef struct packed {
    logic               have;
    logic [SCORE_W-1:0] max_score;
    logic [IDX_W-1:0]   max_slot;
    logic               rd_hit;
    logic [KEY_W-1:0]   rd_key;
    logic [SCORE_W-1:0] rd_score;
  } tkl_sweep_t;

  // Store request to one slot of the table.
  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   slot;
    logic [KEY_W-1:0]   key;
    logic [SCORE_W-1:0] score;
  } tkl_write_t;

endpackage

// ===== rtl/core/top_k_lowest_score_table_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_lowest_score_table_top: bounded table of the lowest-score hits
// Insert, read and clear words on one channel, one result word each.
//
//   channel  direction  handshake            contents
//   in       input      in_valid / in_stall  operation, key, score, slot
//   out      output     out_valid/out_stall  accepted, entry, stored count
//   cfg      input      cfg_wr_en            keep_limit
//
// Clear, the unused operation code and an insert that is not stored give
// their result in the cycle after acceptance. A read and a stored insert
// wait for the sweep to run down the chain of 64 cells, one cell a cycle,
// to find the worst entry or fetch the read slot.
// Reset is synchronous and active low; the table entries are not cleared.
// A word held by out_stall stalls the input only while it blocks delivery.
// ----------------------------------------------------------------------------
module top_k_lowest_score_table_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [tkl_pkg::LIMIT_W-1:0]  cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [tkl_pkg::OP_W-1:0]     in_operation,
  input  logic [tkl_pkg::KEY_W-1:0]    in_hit_key,
  input  logic [tkl_pkg::SCORE_W-1:0]  in_hit_score,
  input  logic [tkl_pkg::SLOT_W-1:0]   in_slot_index,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_accepted,
  output logic                         out_entry_valid,
  output logic [tkl_pkg::KEY_W-1:0]    out_entry_key,
  output logic [tkl_pkg::SCORE_W-1:0]  out_entry_score,
  output logic [tkl_pkg::COUNT_W-1:0]  out_stored_count
);
  import tkl_pkg::*;

  localparam logic [CNT_W-1:0] SWEEP_LEN = CNT_W'(TABLE_DEPTH);

  logic [LIMIT_W-1:0] keep_limit_r;
  logic [CNT_W-1:0]   fill_r, fill_nxt;
  logic [SCORE_W-1:0] worst_score_r, worst_score_nxt;
  logic [IDX_W-1:0]   worst_slot_r, worst_slot_nxt;
  logic               busy_r, busy_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               ins_pass_r;
  logic [SLOT_W-1:0]  rd_slot_r;

  logic               out_valid_r, out_valid_nxt;
  logic               out_accepted_r, out_accepted_nxt;
  logic               out_entry_valid_r, out_entry_valid_nxt;
  logic [KEY_W-1:0]   out_entry_key_r, out_entry_key_nxt;
  logic [SCORE_W-1:0] out_entry_score_r, out_entry_score_nxt;
  logic [COUNT_W-1:0] out_count_r, out_count_nxt;

  logic               in_take;
  logic               sweep_done;
  logic [CMP_W-1:0]   limit_w, fill_w, depth_w;
  logic               append, replace;
  tkl_write_t         wr;
  tkl_sweep_t         sweep_last;

  assign in_stall   = busy_r | (out_valid_r & out_stall);
  assign in_take    = in_valid & ~in_stall;
  assign sweep_done = busy_r && (cnt_r == SWEEP_LEN);

  // A limit of zero acts as one, anything above the depth as the depth.
  assign depth_w = CMP_W'(TABLE_DEPTH);
  assign fill_w  = CMP_W'(fill_r);
  always_comb begin
    limit_w = CMP_W'(keep_limit_r);
    if (limit_w == '0) begin
      limit_w = CMP_W'(1);
    end else if (limit_w > depth_w) begin
      limit_w = depth_w;
    end
  end

  assign append  = in_take && (in_operation == OP_INSERT) && (fill_w < limit_w);
  assign replace = in_take && (in_operation == OP_INSERT) && !(fill_w < limit_w)
                   && (in_hit_score < worst_score_r);

  always_comb begin
    wr.en    = append | replace;
    wr.slot  = append ? fill_r[IDX_W-1:0] : worst_slot_r;
    wr.key   = in_hit_key;
    wr.score = in_hit_score;
  end

  tkl_chain u_chain (
    .clk        (clk),
    .fill       (fill_w),
    .rd_slot    (CMP_W'(rd_slot_r)),
    .wr         (wr),
    .sweep_last (sweep_last)
  );

  always_comb begin
    fill_nxt            = fill_r;
    worst_score_nxt     = worst_score_r;
    worst_slot_nxt      = worst_slot_r;
    busy_nxt            = busy_r;
    cnt_nxt             = busy_r ? cnt_r + CNT_W'(1) : cnt_r;
    out_valid_nxt       = out_valid_r & out_stall;
    out_accepted_nxt    = out_accepted_r;
    out_entry_valid_nxt = out_entry_valid_r;
    out_entry_key_nxt   = out_entry_key_r;
    out_entry_score_nxt = out_entry_score_r;
    out_count_nxt       = out_count_r;

    if (sweep_done) begin
      busy_nxt            = 1'b0;
      out_valid_nxt       = 1'b1;
      out_count_nxt       = COUNT_W'(fill_r);
      out_accepted_nxt    = ins_pass_r;
      out_entry_valid_nxt = ins_pass_r ? 1'b0 : sweep_last.rd_hit;
      out_entry_key_nxt   = ins_pass_r ? '0 : sweep_last.rd_key;
      out_entry_score_nxt = ins_pass_r ? '0 : sweep_last.rd_score;
      if (ins_pass_r) begin
        worst_score_nxt = sweep_last.max_score;
        worst_slot_nxt  = sweep_last.max_slot;
      end
    end

    if (in_take) begin
      out_accepted_nxt    = 1'b0;
      out_entry_valid_nxt = 1'b0;
      out_entry_key_nxt   = '0;
      out_entry_score_nxt = '0;
      case (in_operation)
        OP_INSERT: begin
          if (append) begin
            fill_nxt = fill_r + CNT_W'(1);
          end
          if (append || replace) begin
            busy_nxt = 1'b1;
            cnt_nxt  = '0;
          end else begin
            out_valid_nxt = 1'b1;
            out_count_nxt = COUNT_W'(fill_r);
          end
        end
        OP_READ: begin
          busy_nxt = 1'b1;
          cnt_nxt  = '0;
        end
        OP_CLEAR: begin
          fill_nxt        = '0;
          worst_score_nxt = '1;
          worst_slot_nxt  = '0;
          out_valid_nxt   = 1'b1;
          out_count_nxt   = '0;
        end
        default: begin
          out_valid_nxt = 1'b1;
          out_count_nxt = COUNT_W'(fill_r);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_limit_r  <= LIMIT_RESET;
      fill_r        <= '0;
      worst_score_r <= '1;
      worst_slot_r  <= '0;
      busy_r        <= 1'b0;
      cnt_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        keep_limit_r <= cfg_wr_data;
      end
      fill_r        <= fill_nxt;
      worst_score_r <= worst_score_nxt;
      worst_slot_r  <= worst_slot_nxt;
      busy_r        <= busy_nxt;
      cnt_r         <= cnt_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      ins_pass_r <= (in_operation == OP_INSERT);
      rd_slot_r  <= in_slot_index;
    end
    out_accepted_r    <= out_accepted_nxt;
    out_entry_valid_r <= out_entry_valid_nxt;
    out_entry_key_r   <= out_entry_key_nxt;
    out_entry_score_r <= out_entry_score_nxt;
    out_count_r       <= out_count_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_accepted     = out_accepted_r;
  assign out_entry_valid  = out_entry_valid_r;
  assign out_entry_key    = out_entry_key_r;
  assign out_entry_score  = out_entry_score_r;
  assign out_stored_count = out_count_r;

  // The fill count never passes the table depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(fill_r) <= depth_w)
    else $error("fill count beyond table depth");

  // While a sweep runs no new word is taken.
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> in_stall)
    else $error("input taken during a sweep");

  // The output register is empty when a sweep result lands in it.
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    sweep_done |-> !out_valid_r)
    else $error("sweep result would overwrite a pending word");

  // The fill count seen by the sweep stays put while it runs.
  a_fill_stable: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && $past(busy_r) |-> $stable(fill_r))
    else $error("fill count moved during a sweep");

endmodule

// ===== rtl/core/tkl_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkl_cell: one slot of the table
// Holds one key and score, and each cycle passes the sweep word on to its
// neighbour after folding in its own entry.
// ----------------------------------------------------------------------------
module tkl_cell (
  input  logic                       clk,
  input  logic [tkl_pkg::CMP_W-1:0]  idx,
  input  logic [tkl_pkg::CMP_W-1:0]  fill,
  input  logic [tkl_pkg::CMP_W-1:0]  rd_slot,
  input  tkl_pkg::tkl_write_t        wr,
  input  tkl_pkg::tkl_sweep_t        sweep_in,
  output tkl_pkg::tkl_sweep_t        sweep_out
);
  import tkl_pkg::*;

  logic [KEY_W-1:0]   key_r;
  logic [SCORE_W-1:0] score_r;
  tkl_sweep_t         sweep_r;
  tkl_sweep_t         sweep_nxt;
  logic               held;

  assign held = (idx < fill);

  always_comb begin
    sweep_nxt = sweep_in;
    // Strictly greater keeps the lowest slot on a tie.
    if (held && (!sweep_in.have || (score_r > sweep_in.max_score))) begin
      sweep_nxt.have      = 1'b1;
      sweep_nxt.max_score = score_r;
      sweep_nxt.max_slot  = idx[IDX_W-1:0];
    end
    if (held && (rd_slot == idx)) begin
      sweep_nxt.rd_hit   = 1'b1;
      sweep_nxt.rd_key   = key_r;
      sweep_nxt.rd_score = score_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && (wr.slot == idx[IDX_W-1:0])) begin
      key_r   <= wr.key;
      score_r <= wr.score;
    end
    sweep_r <= sweep_nxt;
  end

  assign sweep_out = sweep_r;

endmodule

// ===== rtl/core/tkl_chain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkl_chain: row of table cells
// Links the cells so that a sweep word enters at slot zero and passes
// through the register of each cell in turn before it leaves the last slot.
// ----------------------------------------------------------------------------
module tkl_chain (
  input  logic                       clk,
  input  logic [tkl_pkg::CMP_W-1:0]  fill,
  input  logic [tkl_pkg::CMP_W-1:0]  rd_slot,
  input  tkl_pkg::tkl_write_t        wr,
  output tkl_pkg::tkl_sweep_t        sweep_last
);
  import tkl_pkg::*;

  tkl_sweep_t link [TABLE_DEPTH+1];

  // The sweep starts empty: nothing found, nothing read.
  assign link[0] = '0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    tkl_cell u_cell (
      .clk       (clk),
      .idx       (CMP_W'(i)),
      .fill      (fill),
      .rd_slot   (rd_slot),
      .wr        (wr),
      .sweep_in  (link[i]),
      .sweep_out (link[i+1])
    );
  end

  assign sweep_last = link[TABLE_DEPTH];

endmodule
